// ===== design/isrch_pkg.sv =====
// Package for the interpolation search block: widths, command codes,
// state encoding and the controller/datapath interface structs.
// No dependencies.
package isrch_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;
  localparam int KEY_W  = 32;
  localparam int PROD_W = KEY_W + IDX_W;
  localparam int STEP_W = $clog2(IDX_W);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    RD_LO,
    RD_HI,
    RD_PROBE
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PROBE,
    ST_RD_P,
    ST_NARROW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    wr_en;
    logic    start;
    rd_sel_t rd_sel;
    logic    cap_kl;
    logic    mul_en;
    logic    div_start;
    logic    probe_set;
    logic    narrow;
    logic    res_load;
    logic    res_found;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic stop;
    logic div_done;
  } sts_t;

endpackage

// ===== design/isrch_div.sv =====
// Iterative restoring divider that yields a narrow quotient, one bit per cycle.
// Depends on isrch_pkg for the operand widths.
module isrch_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [isrch_pkg::PROD_W-1:0]  dividend,
  input  logic [isrch_pkg::KEY_W-1:0]   divisor,
  output logic                          done,
  output logic [isrch_pkg::IDX_W-1:0]   quot
);
  import isrch_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r;
  logic [PROD_W-1:0]   rem_r;
  logic [KEY_W-1:0]    dvs_r;
  logic [IDX_W-1:0]    quot_r;
  logic [PROD_W-1:0]   shifted;
  logic [PROD_W:0]     trial;
  logic                ge;

  always_comb begin
    shifted  = PROD_W'(dvs_r) << step_r;
    trial    = {1'b0, rem_r} - {1'b0, shifted};
    ge       = !trial[PROD_W];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && step_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dvs_r  <= divisor;
      quot_r <= '0;
      step_r <= STEP_W'(IDX_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= trial[PROD_W-1:0];
      end
      quot_r <= {quot_r[IDX_W-2:0], ge};
      step_r <= step_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== design/isrch_dp.sv =====
// Datapath of the interpolation search: key table, search bounds, probe
// arithmetic, entry count register and result payload.
// Depends on isrch_pkg and instantiates isrch_div.
module isrch_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  isrch_pkg::cmd_t               cmd,
  output isrch_pkg::sts_t               sts,
  input  logic [isrch_pkg::IDX_W-1:0]   in_entry_index,
  input  logic signed [isrch_pkg::KEY_W-1:0] in_key_value,
  input  logic                          cfg_wr_en,
  input  logic [isrch_pkg::CNT_W-1:0]   cfg_wr_data,
  output logic                          out_found,
  output logic [isrch_pkg::IDX_W-1:0]   out_found_index
);
  import isrch_pkg::*;

  logic signed [KEY_W-1:0] table_keys_r [DEPTH];
  logic signed [KEY_W-1:0] rdata_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] kl_r;
  logic [CNT_W-1:0]        entry_count_r;
  logic [IDX_W-1:0]        lo_r, hi_r, probe_r;
  logic [PROD_W-1:0]       prod_r;
  logic [KEY_W-1:0]        span_r;
  logic                    out_found_r;
  logic [IDX_W-1:0]        out_index_r;

  logic [CNT_W-1:0]        count_eff;
  logic [IDX_W-1:0]        raddr;
  logic signed [KEY_W:0]   off_w, span_w;
  logic [IDX_W-1:0]        diff;
  logic [PROD_W-1:0]       prod_nxt;
  logic [IDX_W-1:0]        quot;
  logic                    div_done;
  logic [IDX_W-1:0]        probe_nxt;

  isrch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (span_r),
    .done     (div_done),
    .quot     (quot)
  );

  always_comb begin
    count_eff = (entry_count_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : entry_count_r;
    case (cmd.rd_sel)
      RD_LO:    raddr = lo_r;
      RD_HI:    raddr = hi_r;
      RD_PROBE: raddr = probe_r;
      default:  raddr = lo_r;
    endcase
    off_w    = {key_r[KEY_W-1], key_r} - {kl_r[KEY_W-1], kl_r};
    span_w   = {rdata_r[KEY_W-1], rdata_r} - {kl_r[KEY_W-1], kl_r};
    diff     = hi_r - lo_r;
    prod_nxt = PROD_W'(off_w[KEY_W-1:0]) * PROD_W'(diff);
    probe_nxt = lo_r + quot;
    if (quot == '0) begin
      probe_nxt = lo_r + 1'b1;
    end
    if (probe_nxt > hi_r) begin
      probe_nxt = hi_r;
    end
    sts.empty    = (count_eff == '0);
    sts.hit      = (kl_r == key_r);
    sts.stop     = (lo_r == hi_r) || (kl_r == rdata_r) ||
                   (key_r < kl_r) || (key_r > rdata_r);
    sts.div_done = div_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      table_keys_r[in_entry_index] <= in_key_value;
    end
    rdata_r <= table_keys_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wr_en) begin
      entry_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_key_value;
      lo_r  <= '0;
      hi_r  <= IDX_W'(count_eff - 1'b1);
    end else if (cmd.narrow) begin
      if (key_r < rdata_r) begin
        hi_r <= probe_r - 1'b1;
      end else begin
        lo_r <= probe_r;
      end
    end
    if (cmd.cap_kl) begin
      kl_r <= rdata_r;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      span_r <= span_w[KEY_W-1:0];
    end
    if (cmd.probe_set) begin
      probe_r <= probe_nxt;
    end
    if (cmd.res_load) begin
      out_found_r <= cmd.res_found;
      out_index_r <= cmd.res_found ? lo_r : '0;
    end
  end

  assign out_found       = out_found_r;
  assign out_found_index = out_index_r;

endmodule

// ===== design/isrch_ctrl.sv =====
// Controller of the interpolation search: sequences table reads, the
// multiply and divide of each probe, and the output handshake.
// Depends on isrch_pkg.
module isrch_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_command,
  output logic            out_valid,
  input  logic            out_ready,
  input  isrch_pkg::sts_t sts,
  output isrch_pkg::cmd_t cmd
);
  import isrch_pkg::*;

  state_t state_r, state_nxt;
  logic   hit_r, hit_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;
  logic   out_free;

  assign acc      = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_command == CMD_SEARCH) begin
          state_nxt = sts.empty ? ST_DONE : ST_RD_LO;
        end
      end
      ST_RD_LO:    state_nxt = ST_RD_HI;
      ST_RD_HI:    state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = (sts.hit || sts.stop) ? ST_DONE : ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: state_nxt = sts.div_done ? ST_PROBE : ST_DIV_WAIT;
      ST_PROBE:    state_nxt = ST_RD_P;
      ST_RD_P:     state_nxt = ST_NARROW;
      ST_NARROW:   state_nxt = ST_RD_LO;
      ST_DONE:     state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_LO;
    in_ready      = (state_r == ST_IDLE);
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        cmd.wr_en = acc && (in_command == CMD_WRITE);
        cmd.start = acc && (in_command == CMD_SEARCH);
        if (cmd.start) begin
          hit_nxt = 1'b0;
        end
      end
      ST_RD_LO: cmd.rd_sel = RD_LO;
      ST_RD_HI: begin
        cmd.rd_sel = RD_HI;
        cmd.cap_kl = 1'b1;
      end
      ST_CHECK: begin
        cmd.mul_en = 1'b1;
        hit_nxt    = sts.hit;
      end
      ST_DIV_GO:   cmd.div_start = 1'b1;
      ST_DIV_WAIT: cmd.rd_sel    = RD_LO;
      ST_PROBE:    cmd.probe_set = 1'b1;
      ST_RD_P:     cmd.rd_sel    = RD_PROBE;
      ST_NARROW:   cmd.narrow    = 1'b1;
      ST_DONE: begin
        if (out_free) begin
          cmd.res_load  = 1'b1;
          cmd.res_found = hit_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.rd_sel = RD_LO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/interpolation_search.sv =====
// Interpolation search over a 32-entry table of signed 32-bit keys kept in
// ascending order. A write item (command 0) stores one key. A search item
// (command 1) looks among the first entry_count entries and gives one result
// item; each probe reads the bounds and checks them, then computes the probe
// position with the five-step divider and reads the probe entry through the
// single read port of the key table; the output register is loaded last.
// The search answers not found as soon as the key leaves the current end-key
// range. A result waits in the output register while the next item is
// accepted. The table has no reset value; search only over entries that have
// been written.
module interpolation_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [isrch_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [isrch_pkg::KEY_W-1:0]  in_key_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [isrch_pkg::IDX_W-1:0]         out_found_index,
  input  logic                                cfg_wr_en,
  input  logic [isrch_pkg::CNT_W-1:0]         cfg_wr_data
);
  import isrch_pkg::*;

  cmd_t cmd;
  sts_t sts;

  isrch_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  isrch_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_entry_index  (in_entry_index),
    .in_key_value    (in_key_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_found       (out_found),
    .out_found_index (out_found_index)
  );

endmodule

// ===== design/isrch_chk.sv =====
// Port-level checker for the interpolation search block, bound to its top.
// Depends on isrch_pkg for the port widths.
module isrch_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_command,
  input logic [isrch_pkg::IDX_W-1:0]         in_entry_index,
  input logic signed [isrch_pkg::KEY_W-1:0]  in_key_value,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_found,
  input logic [isrch_pkg::IDX_W-1:0]         out_found_index,
  input logic                                cfg_wr_en,
  input logic [isrch_pkg::CNT_W-1:0]         cfg_wr_data
);
  import isrch_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
    $stable(out_found_index))
    else $error("Stalled result item changed or dropped.");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_index == '0)
    else $error("Not-found result carries a nonzero index.");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_WRITE && !out_valid |=> !out_valid)
    else $error("Write item produced a result item.");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_SEARCH |=> !in_ready)
    else $error("Input accepted while a search is in progress.");

endmodule

bind interpolation_search isrch_chk u_isrch_chk (.*);
